// File: hdl/multi_policy_burst_scheduler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the burst scheduler
// Clocked implication checks, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_POLICY_BURST_SCHEDULER_ASSERT_SVH
`define MULTI_POLICY_BURST_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define MPBS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// next-cycle implication
`define MPBS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// File: hdl/mpbs_pkg.sv
// ----------------------------------------------------------------------------
// mpbs_pkg
// Sizes, codes and the queue slot layout for the burst scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package mpbs_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int MAX_THREADS = 16;

    localparam int QIDX_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TIDX_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int TCNT_W = $clog2(MAX_THREADS + 1);
    localparam int CNT_W  = (QCNT_W > TCNT_W) ? QCNT_W : TCNT_W;

    localparam int VR_W   = 48;
    localparam int FAC_W  = 9;
    localparam int PROD_W = 24 + FAC_W;

    // selection rules
    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SJF  = 2'd1;
    localparam logic [1:0] POL_PRIO = 2'd2;
    localparam logic [1:0] POL_VRT  = 2'd3;

    // result status
    localparam logic [2:0] ST_ENQ   = 3'd0;
    localparam logic [2:0] ST_DISP  = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_BAD   = 3'd4;

    // request kinds
    localparam logic REQ_ENQ  = 1'b0;
    localparam logic REQ_DISP = 1'b1;

    // config register indexes
    localparam logic CFG_POLICY  = 1'b0;
    localparam logic CFG_THREADS = 1'b1;

    typedef struct packed {
        logic [4:0]  thread;
        logic [7:0]  burst;
        logic [23:0] length;
        logic [31:0] arrival;
    } t_slot;

    typedef struct packed {
        logic [VR_W-1:0] a;
        logic [VR_W-1:0] b;
    } t_cmp_req;

    typedef struct packed {
        logic            lt;
        logic [VR_W-1:0] diff;
    } t_cmp_rsp;

endpackage

`default_nettype wire

// File: hdl/mpbs_ram.sv
// ----------------------------------------------------------------------------
// mpbs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mpbs_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hdl/mpbs_cmp.sv
// ----------------------------------------------------------------------------
// mpbs_cmp
// Shared subtract/compare unit used by every scan step and the wait time.
// ----------------------------------------------------------------------------
`default_nettype none

module mpbs_cmp (
    input  wire mpbs_pkg::t_cmp_req i_req,
    output mpbs_pkg::t_cmp_rsp      o_rsp
);

    logic [mpbs_pkg::VR_W:0] w_sub;

    // borrow out of the wide subtract gives a < b
    assign w_sub       = {1'b0, i_req.a} - {1'b0, i_req.b};
    assign o_rsp.lt    = w_sub[mpbs_pkg::VR_W];
    assign o_rsp.diff  = w_sub[mpbs_pkg::VR_W-1:0];

endmodule

`default_nettype wire

// File: hdl/multi_policy_burst_scheduler.sv
// ----------------------------------------------------------------------------
// multi_policy_burst_scheduler
// Ready queue of CPU bursts with FCFS, SJF, PRIO and virtual runtime dispatch.
// ----------------------------------------------------------------------------
//  channel | signals                              | dir
//  --------+--------------------------------------+-----
//  in      | i_in_valid/o_in_ready, request word  | in
//  out     | o_out_valid/i_out_ready, result word | out
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_data      | in
//
//  Enqueue and error words go from accept through S_EXEC and S_DONE to the result.
//  Dispatch: FCFS reads the head entry; SJF/PRIO first scan the queue;
//  VRUNTIME scans the thread runtimes, then the queue, then charges the
//  runtime; all then compact the queue. The scans and the compaction each read one RAM entry a cycle.
//  Reset is synchronous; runtimes read as zero until first charged.
//  A result waits in the output register; the next word is taken meanwhile,
//  and the sequencer holds in its last step while the previous word waits.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_policy_burst_scheduler (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [4:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_req_type,
    input  wire logic [4:0]  i_thread_id,
    input  wire logic [7:0]  i_burst_id,
    input  wire logic [23:0] i_burst_length,
    input  wire logic [31:0] i_now_time,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic [4:0]       o_out_thread,
    output logic [7:0]       o_out_burst,
    output logic [23:0]      o_out_length,
    output logic [31:0]      o_out_arrival,
    output logic [31:0]      o_wait_time,
    output logic [5:0]       o_queue_fill
);

    localparam int QIDX_W = mpbs_pkg::QIDX_W;
    localparam int QCNT_W = mpbs_pkg::QCNT_W;
    localparam int TIDX_W = mpbs_pkg::TIDX_W;
    localparam int TCNT_W = mpbs_pkg::TCNT_W;
    localparam int CNT_W  = mpbs_pkg::CNT_W;
    localparam int VR_W   = mpbs_pkg::VR_W;
    localparam int FAC_W  = mpbs_pkg::FAC_W;
    localparam int PROD_W = mpbs_pkg::PROD_W;
    localparam int SLOT_W = $bits(mpbs_pkg::t_slot);

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_VSCAN, S_QSCAN, S_RDK, S_RDK2,
        S_CRD, S_CMUL, S_CADD, S_COMP, S_DONE
    } t_state;

    t_state               r_state;
    logic [1:0]           r_policy;
    logic [4:0]           r_tcount;
    logic [QCNT_W-1:0]    r_fill;
    logic [2:0]           r_st;
    logic                 r_disp;
    logic                 r_req;
    logic [4:0]           r_tid;
    logic [7:0]           r_bid;
    logic [23:0]          r_len;
    logic [31:0]          r_now;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     r_pidx;
    logic                 r_pend;
    logic [QIDX_W-1:0]    r_best;
    logic [VR_W-1:0]      r_bkey;
    logic [TIDX_W-1:0]    r_low;
    logic                 r_found;
    mpbs_pkg::t_slot      r_sel;
    logic [PROD_W-1:0]    r_prod;
    logic [VR_W-1:0]      r_vrv;
    logic [mpbs_pkg::MAX_THREADS-1:0] r_vr_vld;
    logic                 r_vr_rdv;

    logic                 w_q_we;
    logic [QIDX_W-1:0]    w_q_waddr;
    mpbs_pkg::t_slot      w_q_wdata;
    logic [QIDX_W-1:0]    w_q_raddr;
    mpbs_pkg::t_slot      w_q_rdata;
    logic                 w_v_we;
    logic [TIDX_W-1:0]    w_v_waddr;
    logic [VR_W-1:0]      w_v_wdata;
    logic [TIDX_W-1:0]    w_v_raddr;
    logic [VR_W-1:0]      w_v_rdata;
    logic [TCNT_W-1:0]    w_nthr;
    logic                 w_iss;
    logic [VR_W-1:0]      w_vkey;
    logic [VR_W-1:0]      w_qkey;
    logic [VR_W:0]        w_sum;
    logic [FAC_W-1:0]     w_fac;
    logic [TIDX_W-1:0]    w_sel_ti;
    logic                 w_out_free;
    mpbs_pkg::t_cmp_req   w_cmp_req;
    mpbs_pkg::t_cmp_rsp   w_cmp_rsp;

    mpbs_ram #(.DEPTH(mpbs_pkg::QUEUE_DEPTH), .WIDTH(SLOT_W)) u_qram (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_waddr (w_q_waddr),
        .i_wdata (w_q_wdata),
        .i_raddr (w_q_raddr),
        .o_rdata (w_q_rdata)
    );

    mpbs_ram #(.DEPTH(mpbs_pkg::MAX_THREADS), .WIDTH(VR_W)) u_vram (
        .i_clk   (i_clk),
        .i_we    (w_v_we),
        .i_waddr (w_v_waddr),
        .i_wdata (w_v_wdata),
        .i_raddr (w_v_raddr),
        .o_rdata (w_v_rdata)
    );

    mpbs_cmp u_cmp (
        .i_req (w_cmp_req),
        .o_rsp (w_cmp_rsp)
    );

    // thread count clamped to 1..MAX_THREADS
    always_comb begin
        if (r_tcount == 5'd0) begin
            w_nthr = TCNT_W'(1);
        end else if (32'(r_tcount) > 32'(mpbs_pkg::MAX_THREADS)) begin
            w_nthr = TCNT_W'(mpbs_pkg::MAX_THREADS);
        end else begin
            w_nthr = TCNT_W'(r_tcount);
        end
    end

    // scan issue: another read still to go
    always_comb begin
        if (r_state == S_VSCAN) begin
            w_iss = 32'(r_cnt) < 32'(w_nthr);
        end else begin
            w_iss = 32'(r_cnt) < 32'(r_fill);
        end
    end

    // compare keys
    assign w_vkey = r_vr_rdv ? w_v_rdata : '0;
    assign w_qkey = (r_policy == mpbs_pkg::POL_SJF) ? VR_W'(w_q_rdata.length)
                                                    : VR_W'(w_q_rdata.thread);

    // shared compare unit operands
    always_comb begin
        case (r_state)
            S_VSCAN: begin
                w_cmp_req.a = w_vkey;
                w_cmp_req.b = r_bkey;
            end
            S_QSCAN: begin
                w_cmp_req.a = w_qkey;
                w_cmp_req.b = r_bkey;
            end
            default: begin
                w_cmp_req.a = VR_W'(r_now);
                w_cmp_req.b = VR_W'(r_sel.arrival);
            end
        endcase
    end

    // runtime charge
    assign w_sel_ti = TIDX_W'(r_sel.thread - 5'd1);
    assign w_fac    = FAC_W'(7) + FAC_W'(3) * FAC_W'(r_sel.thread);
    assign w_sum    = {1'b0, r_vrv} + (VR_W + 1)'(r_prod);

    // queue RAM ports
    always_comb begin
        w_q_we    = 1'b0;
        w_q_waddr = r_fill[QIDX_W-1:0];
        w_q_wdata = {r_tid, r_bid, r_len, r_now};
        w_q_raddr = r_cnt[QIDX_W-1:0];
        case (r_state)
            S_EXEC: begin
                w_q_we = (r_req == mpbs_pkg::REQ_ENQ) && (r_tid != 5'd0)
                      && (32'(r_tid) <= 32'(mpbs_pkg::MAX_THREADS))
                      && (32'(r_fill) < 32'(mpbs_pkg::QUEUE_DEPTH));
            end
            S_RDK: begin
                w_q_raddr = r_best;
            end
            S_COMP: begin
                w_q_we    = r_pend;
                w_q_waddr = QIDX_W'(r_pidx - CNT_W'(1));
                w_q_wdata = w_q_rdata;
            end
            default: begin
                w_q_we = 1'b0;
            end
        endcase
    end

    // runtime RAM ports
    always_comb begin
        w_v_we    = (r_state == S_CADD);
        w_v_waddr = w_sel_ti;
        w_v_wdata = w_sum[VR_W] ? {VR_W{1'b1}} : w_sum[VR_W-1:0];
        w_v_raddr = (r_state == S_CRD) ? w_sel_ti : r_cnt[TIDX_W-1:0];
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign w_out_free = !o_out_valid || i_out_ready;

    // sequencer, config and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_policy    <= mpbs_pkg::POL_FCFS;
            r_tcount    <= 5'd16;
            r_fill      <= '0;
            r_vr_vld    <= '0;
            r_pend      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == mpbs_pkg::CFG_POLICY) begin
                    r_policy <= i_cfg_data[1:0];
                end else begin
                    r_tcount <= i_cfg_data;
                end
            end
            // the last step loads a new word itself
            if (o_out_valid && i_out_ready && (r_state != S_DONE)) begin
                o_out_valid <= 1'b0;
            end
            r_vr_rdv <= r_vr_vld[w_v_raddr];

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_req_type;
                        r_tid   <= i_thread_id;
                        r_bid   <= i_burst_id;
                        r_len   <= i_burst_length;
                        r_now   <= i_now_time;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_disp  <= 1'b0;
                    r_best  <= '0;
                    r_found <= 1'b0;
                    r_low   <= '0;
                    r_cnt   <= '0;
                    r_pend  <= 1'b0;
                    if (r_req == mpbs_pkg::REQ_ENQ) begin
                        r_state <= S_DONE;
                        if (w_q_we) begin
                            r_fill <= r_fill + QCNT_W'(1);
                            r_st   <= mpbs_pkg::ST_ENQ;
                        end else if ((r_tid == 5'd0)
                                || (32'(r_tid) > 32'(mpbs_pkg::MAX_THREADS))) begin
                            r_st <= mpbs_pkg::ST_BAD;
                        end else begin
                            r_st <= mpbs_pkg::ST_FULL;
                        end
                    end else if (r_fill == '0) begin
                        r_st    <= mpbs_pkg::ST_EMPTY;
                        r_state <= S_DONE;
                    end else begin
                        r_st   <= mpbs_pkg::ST_DISP;
                        r_disp <= 1'b1;
                        case (r_policy)
                            mpbs_pkg::POL_FCFS: r_state <= S_RDK;
                            mpbs_pkg::POL_VRT:  r_state <= S_VSCAN;
                            default:            r_state <= S_QSCAN;
                        endcase
                    end
                end
                // lowest runtime over the active threads
                S_VSCAN: begin
                    r_pend <= w_iss;
                    r_pidx <= r_cnt;
                    if (w_iss) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    if (r_pend && ((r_pidx == '0) || w_cmp_rsp.lt)) begin
                        r_low  <= TIDX_W'(r_pidx);
                        r_bkey <= w_vkey;
                    end
                    if (!w_iss && !r_pend) begin
                        r_cnt   <= '0;
                        r_state <= S_QSCAN;
                    end
                end
                // queue walk: min key, or first burst of the chosen thread
                S_QSCAN: begin
                    r_pend <= w_iss;
                    r_pidx <= r_cnt;
                    if (w_iss) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    if (r_pend) begin
                        if (r_policy == mpbs_pkg::POL_VRT) begin
                            if (!r_found
                                && (32'(w_q_rdata.thread) == 32'(r_low) + 32'd1)) begin
                                r_best  <= QIDX_W'(r_pidx);
                                r_found <= 1'b1;
                            end
                        end else if ((r_pidx == '0) || w_cmp_rsp.lt) begin
                            r_best <= QIDX_W'(r_pidx);
                            r_bkey <= w_qkey;
                        end
                    end
                    if (!w_iss && !r_pend) begin
                        r_state <= S_RDK;
                    end
                end
                S_RDK: begin
                    r_state <= S_RDK2;
                end
                S_RDK2: begin
                    r_sel  <= w_q_rdata;
                    r_cnt  <= CNT_W'(r_best) + CNT_W'(1);
                    r_pend <= 1'b0;
                    if (r_policy == mpbs_pkg::POL_VRT) begin
                        r_state <= S_CRD;
                    end else begin
                        r_state <= S_COMP;
                    end
                end
                S_CRD: begin
                    r_state <= S_CMUL;
                end
                S_CMUL: begin
                    r_prod  <= PROD_W'(r_sel.length) * PROD_W'(w_fac);
                    r_vrv   <= w_vkey;
                    r_state <= S_CADD;
                end
                S_CADD: begin
                    r_vr_vld[w_sel_ti] <= 1'b1;
                    r_state            <= S_COMP;
                end
                // close the gap, one entry a cycle
                S_COMP: begin
                    r_pend <= w_iss;
                    r_pidx <= r_cnt;
                    if (w_iss) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    if (!w_iss && !r_pend) begin
                        r_fill  <= r_fill - QCNT_W'(1);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        o_out_valid  <= 1'b1;
                        o_status     <= r_st;
                        o_queue_fill <= 6'(r_fill);
                        if (r_disp) begin
                            o_out_thread  <= r_sel.thread;
                            o_out_burst   <= r_sel.burst;
                            o_out_length  <= r_sel.length;
                            o_out_arrival <= r_sel.arrival;
                            o_wait_time   <= w_cmp_rsp.lt ? 32'd0 : w_cmp_rsp.diff[31:0];
                        end else begin
                            o_out_thread  <= '0;
                            o_out_burst   <= '0;
                            o_out_length  <= '0;
                            o_out_arrival <= '0;
                            o_wait_time   <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/mpbs_chk.sv
// ----------------------------------------------------------------------------
// mpbs_chk
// Port-level checks on the scheduler's result channel, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_policy_burst_scheduler_assert.svh"

module mpbs_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  o_status,
    input wire logic [4:0]  o_out_thread,
    input wire logic [31:0] o_wait_time,
    input wire logic [5:0]  o_queue_fill
);

    // a stalled word holds
    `MPBS_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status) && $stable(o_queue_fill))

    // non-dispatch words carry no burst
    `MPBS_ASSERT_NOW(a_nodisp, i_clk, i_rst_n, o_out_valid && (o_status != mpbs_pkg::ST_DISP), (o_out_thread == 5'd0) && (o_wait_time == 32'd0))

    // a dispatched burst always has a real thread
    `MPBS_ASSERT_NOW(a_thread, i_clk, i_rst_n, o_out_valid && (o_status == mpbs_pkg::ST_DISP), (o_out_thread != 5'd0) && (32'(o_out_thread) <= 32'(mpbs_pkg::MAX_THREADS)))

    // fill never passes the queue depth
    `MPBS_ASSERT_NOW(a_fill, i_clk, i_rst_n, o_out_valid, 32'(o_queue_fill) <= 32'(mpbs_pkg::QUEUE_DEPTH))

endmodule

bind multi_policy_burst_scheduler mpbs_chk u_mpbs_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_status     (o_status),
    .o_out_thread (o_out_thread),
    .o_wait_time  (o_wait_time),
    .o_queue_fill (o_queue_fill)
);

`default_nettype wire
